>>> rtl/gbt_pkg.sv
// ----------------------------------------------------------------------------
// gbt_pkg: shared types and constants of the graph traversal block
// Field widths, request op codes and result status codes.
// ----------------------------------------------------------------------------
package gbt_pkg;

    localparam int VERTEX_W = 4;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int VCOUNT_W = 5;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_ADD_EDGE = 2'd0,
        OP_BFS      = 2'd1,
        OP_DFS      = 2'd2,
        OP_CLEAR    = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

endpackage

>>> rtl/gbt_req_if.sv
// ----------------------------------------------------------------------------
// gbt_req_if: request channel of the graph traversal block
// Valid/ready handshake carrying one op and two vertex numbers.
// ----------------------------------------------------------------------------
interface gbt_req_if;
    import gbt_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [VERTEX_W-1:0] vertex_a;
    logic [VERTEX_W-1:0] vertex_b;

    modport source (output valid, output op, output vertex_a, output vertex_b,
                    input ready);
    modport sink   (input valid, input op, input vertex_a, input vertex_b,
                    output ready);
endinterface

>>> rtl/gbt_rsp_if.sv
// ----------------------------------------------------------------------------
// gbt_rsp_if: result channel of the graph traversal block
// Valid/ready handshake carrying a visited vertex, a status and a last flag.
// ----------------------------------------------------------------------------
interface gbt_rsp_if;
    import gbt_pkg::*;

    logic                valid;
    logic                ready;
    logic [VERTEX_W-1:0] visit_vertex;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, output visit_vertex, output status, output last,
                    input ready);
    modport sink   (input valid, input visit_vertex, input status, input last,
                    output ready);
endinterface

>>> rtl/graph_bfs_dfs_traversal.sv
// ----------------------------------------------------------------------------
// graph_bfs_dfs_traversal: undirected graph store with BFS and DFS walks
// Per-vertex neighbor lists in insertion order, walked breadth-first or
// depth-first preorder by a small sequencer over single-port memories.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request: add edge, breadth-first walk, depth-first
//   walk or clear all edges. o_rsp returns results; the final result of a
//   request has last set. Add edge and clear give one result, a walk gives
//   one result per visited vertex in visit order. An invalid vertex number
//   or a full neighbor list gives a single result with the error status.
//   i_cfg_we/i_cfg_wdata write vertex_count; write it only while idle.
// Request flow:
//   The block takes one request at a time and drops i_req.ready until the
//   request's last result is in the output register. Add edge reads the
//   count memory once per end, then writes one list entry per end; a full
//   list is found after both count reads. A breadth-first walk checks each
//   neighbor entry while it reads the next, a depth-first walk reads and
//   checks each entry in turn; both are bound by the one read port of the
//   neighbor memory.
// Reset and back-pressure:
//   Reset empties every list (count valid bits clear) and sets vertex_count
//   to 16. A stalled o_rsp holds the result register; the sequencer waits
//   only when it needs the slot again.
// ----------------------------------------------------------------------------
module graph_bfs_dfs_traversal #(
    parameter int MAX_VERTICES = 16,
    parameter int MAX_DEGREE   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gbt_pkg::VCOUNT_W-1:0]  i_cfg_wdata,
    gbt_req_if.sink                       i_req,
    gbt_rsp_if.source                     o_rsp
);
    import gbt_pkg::*;

    // Vertex index, position index, count, depth and compare widths
    localparam int VW   = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
    localparam int DW   = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int CW   = $clog2(MAX_DEGREE + 1);
    localparam int LW   = $clog2(MAX_VERTICES + 1);
    localparam int VCW  = ($clog2(MAX_VERTICES + 1) > VCOUNT_W) ?
                          $clog2(MAX_VERTICES + 1) : VCOUNT_W;
    localparam int NBR_DEPTH = MAX_VERTICES * (2 ** DW);

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_ADD_RDB  = 13'b0000000000010,
        S_ADD_CHK  = 13'b0000000000100,
        S_ADD_WRB  = 13'b0000000001000,
        S_RESP     = 13'b0000000010000,
        S_BFS_POP  = 13'b0000000100000,
        S_BFS_HEAD = 13'b0000001000000,
        S_BFS_SCAN = 13'b0000010000000,
        S_DFS_CNT  = 13'b0000100000000,
        S_DFS_STEP = 13'b0001000000000,
        S_DFS_CHK  = 13'b0010000000000,
        S_DFS_POP  = 13'b0100000000000,
        S_FIN      = 13'b1000000000000
    } t_state;

    // ---------------- state ----------------
    t_state                r_state, n_state;
    logic [VCOUNT_W-1:0]   r_vcount;
    logic [VERTEX_W-1:0]   r_a, n_a;
    logic [VERTEX_W-1:0]   r_b, n_b;
    t_status               r_status, n_status;
    logic [MAX_VERTICES-1:0] r_visited, n_visited;
    logic [LW-1:0]         r_head, n_head;
    logic [LW-1:0]         r_tail, n_tail;     // queue tail, or stack depth
    logic [VERTEX_W-1:0]   r_u, n_u;           // vertex being expanded
    logic [CW-1:0]         r_p, n_p;           // next neighbor position
    logic                  r_chk_v, n_chk_v;   // neighbor read in flight (BFS)
    logic                  r_pend_v, n_pend_v; // visit held back for last flag
    logic [VERTEX_W-1:0]   r_pend, n_pend;
    logic [CW-1:0]         r_cnt_a, n_cnt_a;
    logic [CW-1:0]         r_cnt_b, n_cnt_b;

    // Output register
    logic                  r_out_v;
    logic [VERTEX_W-1:0]   r_out_vertex;
    logic [STATUS_W-1:0]   r_out_status;
    logic                  r_out_last;
    logic                  out_ld;
    logic [VERTEX_W-1:0]   out_vertex;
    t_status               out_status;
    logic                  out_last;
    logic                  out_free;

    // Neighbor memory: row per vertex, column per list position
    logic [VERTEX_W-1:0]   r_nbr_mem [NBR_DEPTH];
    logic [VERTEX_W-1:0]   r_nbr_rd;
    logic                  nbr_we, nbr_re;
    logic [VW+DW-1:0]      nbr_waddr, nbr_raddr;
    logic [VERTEX_W-1:0]   nbr_wdata;

    // List length memory with per-entry valid bits (invalid reads as zero)
    logic [CW-1:0]         r_cnt_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_cnt_vld;
    logic [CW-1:0]         r_cnt_rd;
    logic                  r_cnt_rd_vld;
    logic                  cnt_we, cnt_re, cnt_clr;
    logic [VW-1:0]         cnt_waddr, cnt_raddr;
    logic [CW-1:0]         cnt_wdata;
    logic [CW-1:0]         cnt_val;

    // Work list (queue or stack) and stack positions
    logic [VERTEX_W-1:0]   r_wl_mem [MAX_VERTICES];
    logic [CW-1:0]         r_dp_mem [MAX_VERTICES];
    logic [VERTEX_W-1:0]   r_wl_rd;
    logic [CW-1:0]         r_dp_rd;
    logic                  wl_we, wl_re;
    logic [VW-1:0]         wl_waddr, wl_raddr;
    logic [VERTEX_W-1:0]   wl_wdata;
    logic [CW-1:0]         dp_wdata;

    // Combinational helpers
    logic [VCW-1:0]        vc;
    logic                  acc;
    logic                  a_ok, b_ok;
    logic [VERTEX_W-1:0]   w;
    logic                  w_new;
    logic                  visit_go;
    logic                  full;
    logic [CW:0]           cnt_a_ext, cnt_b_ext;
    logic                  more;

    assign cnt_val  = r_cnt_rd_vld ? r_cnt_rd : '0;
    assign out_free = !r_out_v || o_rsp.ready;
    assign visit_go = !r_pend_v || out_free;
    assign acc      = i_req.valid && (r_state == S_IDLE);
    assign a_ok     = VCW'(i_req.vertex_a) < vc;
    assign b_ok     = VCW'(i_req.vertex_b) < vc;
    assign w        = r_nbr_rd;
    assign more     = r_p < cnt_val;

    // Effective vertex count: clamp at MAX_VERTICES
    always_comb begin
        if (VCW'(r_vcount) > VCW'(MAX_VERTICES)) begin
            vc = VCW'(MAX_VERTICES);
        end else begin
            vc = VCW'(r_vcount);
        end
    end

    // Neighbor is taken if in range, not yet visited and the list has room
    assign w_new = (VCW'(w) < vc) && !r_visited[VW'(w)]
                   && (r_tail < LW'(MAX_VERTICES));

    always_comb begin
        cnt_a_ext = {1'b0, r_cnt_a};
        cnt_b_ext = {1'b0, cnt_val};
        full = (cnt_a_ext >= (CW+1)'(MAX_DEGREE)) || (cnt_b_ext >= (CW+1)'(MAX_DEGREE))
               || ((r_a == r_b) && (cnt_a_ext + (CW+1)'(2) > (CW+1)'(MAX_DEGREE)));
    end

    assign i_req.ready = (r_state == S_IDLE);

    // ---------------- sequencer ----------------
    always_comb begin
        n_state   = r_state;
        n_a       = r_a;
        n_b       = r_b;
        n_status  = r_status;
        n_visited = r_visited;
        n_head    = r_head;
        n_tail    = r_tail;
        n_u       = r_u;
        n_p       = r_p;
        n_chk_v   = r_chk_v;
        n_pend_v  = r_pend_v;
        n_pend    = r_pend;
        n_cnt_a   = r_cnt_a;
        n_cnt_b   = r_cnt_b;

        out_ld     = 1'b0;
        out_vertex = r_pend;
        out_status = ST_OK;
        out_last   = 1'b0;

        nbr_we = 1'b0; nbr_waddr = '0; nbr_wdata = '0;
        nbr_re = 1'b0; nbr_raddr = {VW'(r_u), r_p[DW-1:0]};
        cnt_we = 1'b0; cnt_waddr = '0; cnt_wdata = '0;
        cnt_re = 1'b0; cnt_raddr = VW'(r_u);
        cnt_clr = 1'b0;
        wl_we  = 1'b0; wl_waddr = '0; wl_wdata = '0; dp_wdata = '0;
        wl_re  = 1'b0; wl_raddr = r_head[VW-1:0];

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_a = i_req.vertex_a;
                    n_b = i_req.vertex_b;
                    case (t_op'(i_req.op))
                        OP_CLEAR: begin
                            cnt_clr  = 1'b1;
                            n_status = ST_OK;
                            n_state  = S_RESP;
                        end
                        OP_ADD_EDGE: begin
                            if (!(a_ok && b_ok)) begin
                                n_status = ST_INVALID;
                                n_state  = S_RESP;
                            end else begin
                                cnt_re    = 1'b1;
                                cnt_raddr = VW'(i_req.vertex_a);
                                n_state   = S_ADD_RDB;
                            end
                        end
                        default: begin
                            if (!a_ok) begin
                                n_status = ST_INVALID;
                                n_state  = S_RESP;
                            end else begin
                                n_visited = '0;
                                n_visited[VW'(i_req.vertex_a)] = 1'b1;
                                if (t_op'(i_req.op) == OP_BFS) begin
                                    // Seed the queue with the start vertex
                                    wl_we    = 1'b1;
                                    wl_waddr = '0;
                                    wl_wdata = i_req.vertex_a;
                                    n_head   = '0;
                                    n_tail   = LW'(1);
                                    n_state  = S_BFS_POP;
                                end else begin
                                    // Start vertex is the first visit and top of stack
                                    n_pend   = i_req.vertex_a;
                                    n_pend_v = 1'b1;
                                    n_u      = i_req.vertex_a;
                                    n_p      = '0;
                                    n_tail   = LW'(1);
                                    n_state  = S_DFS_CNT;
                                end
                            end
                        end
                    endcase
                end
            end

            S_ADD_RDB: begin
                n_cnt_a   = cnt_val;
                cnt_re    = 1'b1;
                cnt_raddr = VW'(r_b);
                n_state   = S_ADD_CHK;
            end

            S_ADD_CHK: begin
                if (full) begin
                    n_status = ST_FULL;
                    n_state  = S_RESP;
                end else begin
                    nbr_we    = 1'b1;
                    nbr_waddr = {VW'(r_a), r_cnt_a[DW-1:0]};
                    nbr_wdata = r_b;
                    cnt_we    = 1'b1;
                    cnt_waddr = VW'(r_a);
                    cnt_wdata = CW'(r_cnt_a + 1'b1);
                    // A self loop appends its second entry after the first
                    n_cnt_b   = (r_a == r_b) ? CW'(r_cnt_a + 1'b1) : cnt_val;
                    n_state   = S_ADD_WRB;
                end
            end

            S_ADD_WRB: begin
                nbr_we    = 1'b1;
                nbr_waddr = {VW'(r_b), r_cnt_b[DW-1:0]};
                nbr_wdata = r_a;
                cnt_we    = 1'b1;
                cnt_waddr = VW'(r_b);
                cnt_wdata = CW'(r_cnt_b + 1'b1);
                n_status  = ST_OK;
                n_state   = S_RESP;
            end

            S_RESP: begin
                if (out_free) begin
                    out_ld     = 1'b1;
                    out_vertex = '0;
                    out_status = r_status;
                    out_last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end

            S_BFS_POP: begin
                if (r_head < r_tail) begin
                    wl_re    = 1'b1;
                    wl_raddr = r_head[VW-1:0];
                    n_head   = LW'(r_head + 1'b1);
                    n_state  = S_BFS_HEAD;
                end else begin
                    n_state = S_FIN;
                end
            end

            S_BFS_HEAD: begin
                // Visit the popped vertex; the previous visit goes out now
                if (visit_go) begin
                    if (r_pend_v) begin
                        out_ld = 1'b1;
                    end
                    n_pend    = r_wl_rd;
                    n_pend_v  = 1'b1;
                    n_u       = r_wl_rd;
                    n_p       = '0;
                    n_chk_v   = 1'b0;
                    cnt_re    = 1'b1;
                    cnt_raddr = VW'(r_wl_rd);
                    n_state   = S_BFS_SCAN;
                end
            end

            S_BFS_SCAN: begin
                // Check last cycle's neighbor while reading the next one
                if (r_chk_v && w_new) begin
                    n_visited[VW'(w)] = 1'b1;
                    wl_we    = 1'b1;
                    wl_waddr = r_tail[VW-1:0];
                    wl_wdata = w;
                    n_tail   = LW'(r_tail + 1'b1);
                end
                if (more) begin
                    nbr_re    = 1'b1;
                    nbr_raddr = {VW'(r_u), r_p[DW-1:0]};
                    n_p       = CW'(r_p + 1'b1);
                    n_chk_v   = 1'b1;
                end else begin
                    n_chk_v = 1'b0;
                    if (!r_chk_v) begin
                        n_state = S_BFS_POP;
                    end
                end
            end

            S_DFS_CNT: begin
                cnt_re    = 1'b1;
                cnt_raddr = VW'(r_u);
                n_state   = S_DFS_STEP;
            end

            S_DFS_STEP: begin
                if (more) begin
                    nbr_re    = 1'b1;
                    nbr_raddr = {VW'(r_u), r_p[DW-1:0]};
                    n_p       = CW'(r_p + 1'b1);
                    n_state   = S_DFS_CHK;
                end else if (r_tail == LW'(1)) begin
                    n_state = S_FIN;
                end else begin
                    // Pop: reload the level below from the stack
                    n_tail   = LW'(r_tail - 1'b1);
                    wl_re    = 1'b1;
                    wl_raddr = VW'(r_tail - LW'(2));
                    n_state  = S_DFS_POP;
                end
            end

            S_DFS_CHK: begin
                if (w_new) begin
                    if (visit_go) begin
                        if (r_pend_v) begin
                            out_ld = 1'b1;
                        end
                        n_pend   = w;
                        n_pend_v = 1'b1;
                        n_visited[VW'(w)] = 1'b1;
                        // Push: save the current level, descend into w
                        wl_we    = 1'b1;
                        wl_waddr = VW'(r_tail - 1'b1);
                        wl_wdata = r_u;
                        dp_wdata = r_p;
                        n_u      = w;
                        n_p      = '0;
                        n_tail   = LW'(r_tail + 1'b1);
                        n_state  = S_DFS_CNT;
                    end
                end else begin
                    n_state = S_DFS_STEP;
                end
            end

            S_DFS_POP: begin
                n_u     = r_wl_rd;
                n_p     = r_dp_rd;
                n_state = S_DFS_CNT;
            end

            S_FIN: begin
                if (out_free) begin
                    out_ld     = 1'b1;
                    out_vertex = r_pend;
                    out_last   = 1'b1;
                    n_pend_v   = 1'b0;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_vcount  <= VCOUNT_RESET;
            r_pend_v  <= 1'b0;
            r_chk_v   <= 1'b0;
            r_out_v   <= 1'b0;
            r_cnt_vld <= '0;
            r_head    <= '0;
            r_tail    <= '0;
        end else begin
            r_state  <= n_state;
            r_pend_v <= n_pend_v;
            r_chk_v  <= n_chk_v;
            r_head   <= n_head;
            r_tail   <= n_tail;
            if (i_cfg_we) begin
                r_vcount <= i_cfg_wdata;
            end
            if (out_ld) begin
                r_out_v <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_v <= 1'b0;
            end
            if (cnt_clr) begin
                r_cnt_vld <= '0;
            end else if (cnt_we) begin
                r_cnt_vld[cnt_waddr] <= 1'b1;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        r_a       <= n_a;
        r_b       <= n_b;
        r_status  <= n_status;
        r_visited <= n_visited;
        r_u       <= n_u;
        r_p       <= n_p;
        r_pend    <= n_pend;
        r_cnt_a   <= n_cnt_a;
        r_cnt_b   <= n_cnt_b;
        if (out_ld) begin
            r_out_vertex <= out_vertex;
            r_out_status <= out_status;
            r_out_last   <= out_last;
        end
    end

    // ---------------- memories ----------------
    always_ff @(posedge i_clk) begin
        if (nbr_we) begin
            r_nbr_mem[nbr_waddr] <= nbr_wdata;
        end
        if (nbr_re) begin
            r_nbr_rd <= r_nbr_mem[nbr_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re) begin
            r_cnt_rd     <= r_cnt_mem[cnt_raddr];
            r_cnt_rd_vld <= r_cnt_vld[cnt_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wl_we) begin
            r_wl_mem[wl_waddr] <= wl_wdata;
            r_dp_mem[wl_waddr] <= dp_wdata;
        end
        if (wl_re) begin
            r_wl_rd <= r_wl_mem[wl_raddr];
            r_dp_rd <= r_dp_mem[wl_raddr];
        end
    end

    // ---------------- result port ----------------
    assign o_rsp.valid        = r_out_v;
    assign o_rsp.visit_vertex = r_out_vertex;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.last         = r_out_last;

endmodule

>>> test/tb_graph_bfs_dfs_traversal.sv
// ----------------------------------------------------------------------------
// tb_graph_bfs_dfs_traversal: self-checking bench for the graph traversal block
// Sends add-edge, clear and walk requests and keeps its own copy of the
// neighbor lists. From that copy it predicts every result: the status of
// edge requests and the breadth-first or depth-first visit order of walks.
// A checker compares each result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_graph_bfs_dfs_traversal;
    timeunit 1ns;
    timeprecision 1ps;
    import gbt_pkg::*;

    localparam int NV           = 16;
    localparam int ND           = 16;
    localparam int LIMIT_CYCLES = 2_000_000;

    // one result as the block returns it
    typedef struct packed {
        logic [VERTEX_W-1:0] vertex;
        t_status             status;
        logic                last;
    } t_visit;

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_we;
    logic [VCOUNT_W-1:0] cfg_wdata;

    gbt_req_if req_ch ();
    gbt_rsp_if rsp_ch ();

    graph_bfs_dfs_traversal #(
        .MAX_VERTICES (NV),
        .MAX_DEGREE   (ND)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    // Shadow copy of the graph: neighbor lists in insertion order and the
    // vertex_count register as last written.
    logic [VERTEX_W-1:0] graph_nbr [NV][ND];
    int                  graph_deg [NV];
    logic [VCOUNT_W-1:0] shadow_vcount;

    // Predicted results, oldest first.
    t_visit expected_visits [$];

    int send_gap_pct;
    int rsp_gap_pct;
    int rsp_hold_cycles;
    int cycle_count;
    int error_count;
    int requests_sent;
    int results_checked;
    int vcount_writes;
    int longest_walk;
    int op_count [4];

    // ------------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // End the run with a failure once cycle_count passes LIMIT_CYCLES.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, expected_visits.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: random ready, with a long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rsp_hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold_cycles--;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_gap_pct);
        end
    end

    // Compare every accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        t_visit want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_visits.size() == 0) begin
                $error("result with no request pending: visit_vertex %0d status %0d last %0d",
                       rsp_ch.visit_vertex, rsp_ch.status, rsp_ch.last);
                error_count++;
            end else begin
                want = expected_visits.pop_front();
                if (rsp_ch.visit_vertex !== want.vertex) begin
                    $error("visit_vertex: expected %0d, actual %0d",
                           want.vertex, rsp_ch.visit_vertex);
                    error_count++;
                end
                if (rsp_ch.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                    error_count++;
                end
                if (rsp_ch.last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, rsp_ch.last);
                    error_count++;
                end
            end
            results_checked++;
        end
    end

    // ------------------------------------------------------------------------
    // Graph predictor: apply one accepted request to the shadow lists and
    // queue the results it must produce.
    // ------------------------------------------------------------------------
    function automatic void predict_request(t_op op, logic [VERTEX_W-1:0] a,
                                            logic [VERTEX_W-1:0] b);
        t_visit              walk [$];
        t_visit              closing;
        logic [VERTEX_W-1:0] order [NV];
        int                  pos [NV];
        logic [NV-1:0]       seen;
        int                  live, head, tail, lvl, u, w, p;

        // register values above the vertex range count as the full range
        live = (shadow_vcount > NV) ? NV : int'(shadow_vcount);
        seen = '0;

        if (op == OP_CLEAR) begin
            foreach (graph_deg[i]) graph_deg[i] = 0;
            walk.push_back('{vertex: '0, status: ST_OK, last: 1'b0});
        end else if (a >= live || (op == OP_ADD_EDGE && b >= live)) begin
            // invalid vertex: nothing changes
            walk.push_back('{vertex: '0, status: ST_INVALID, last: 1'b0});
        end else if (op == OP_ADD_EDGE) begin
            // a self loop takes two places in the same list
            if ((a == b && graph_deg[a] + 2 > ND) ||
                graph_deg[a] >= ND || graph_deg[b] >= ND) begin
                walk.push_back('{vertex: '0, status: ST_FULL, last: 1'b0});
            end else begin
                graph_nbr[a][graph_deg[a]] = b;
                graph_deg[a]++;
                graph_nbr[b][graph_deg[b]] = a;
                graph_deg[b]++;
                walk.push_back('{vertex: '0, status: ST_OK, last: 1'b0});
            end
        end else if (op == OP_BFS) begin
            // FIFO walk; stale and visited neighbors are skipped
            order[0] = a;
            seen[a]  = 1'b1;
            head     = 0;
            tail     = 1;
            while (head < tail) begin
                u = order[head];
                head++;
                walk.push_back('{vertex: VERTEX_W'(u), status: ST_OK, last: 1'b0});
                for (p = 0; p < graph_deg[u]; p++) begin
                    w = graph_nbr[u][p];
                    if (w < live && !seen[w] && tail < NV) begin
                        seen[w]     = 1'b1;
                        order[tail] = VERTEX_W'(w);
                        tail++;
                    end
                end
            end
        end else begin
            // preorder walk over a stack of vertex and next list position
            order[0] = a;
            pos[0]   = 0;
            lvl      = 1;
            seen[a]  = 1'b1;
            walk.push_back('{vertex: a, status: ST_OK, last: 1'b0});
            while (lvl > 0) begin
                u = order[lvl-1];
                p = pos[lvl-1];
                if (p < graph_deg[u]) begin
                    w          = graph_nbr[u][p];
                    pos[lvl-1] = p + 1;
                    if (w < live && !seen[w] && lvl < NV) begin
                        seen[w] = 1'b1;
                        walk.push_back('{vertex: VERTEX_W'(w), status: ST_OK, last: 1'b0});
                        order[lvl] = VERTEX_W'(w);
                        pos[lvl]   = 0;
                        lvl++;
                    end
                end else begin
                    lvl--;
                end
            end
        end

        // mark the final result of the request
        closing      = walk.pop_back();
        closing.last = 1'b1;
        walk.push_back(closing);
        if (walk.size() > longest_walk) longest_walk = walk.size();
        foreach (walk[i]) expected_visits.push_back(walk[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    // Offer one request and hold it until accepted. Valid stays high on
    // return so a following request can go out back to back; callers that
    // stop sending drop it through wait_until_idle.
    task automatic send_request(t_op op, logic [VERTEX_W-1:0] a, logic [VERTEX_W-1:0] b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_gap_pct) gap++;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.op       <= op;
        req_ch.vertex_a <= a;
        req_ch.vertex_b <= b;
        do @(posedge i_clk); while (!req_ch.ready);
        predict_request(op, a, b);
        requests_sent++;
        op_count[op]++;
    endtask

    // Drop valid and wait until every predicted result has come back. The
    // block is idle once its last result is taken; add a short margin.
    task automatic wait_until_idle();
        req_ch.valid <= 1'b0;
        while (expected_visits.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write vertex_count; only called while idle.
    task automatic write_vertex_count(logic [VCOUNT_W-1:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge i_clk);
        cfg_we        <= 1'b0;
        shadow_vcount  = value;
        vcount_writes++;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Walks on the empty graph right after reset visit only the start vertex.
    task automatic test_empty_graph();
        send_request(OP_BFS, 4'd5, 4'd0);
        send_request(OP_DFS, 4'd0, 4'd15);
    endtask

    // Edge ends at both extremes, a repeated edge and mixed bit patterns.
    task automatic test_edge_extremes();
        send_request(OP_ADD_EDGE, 4'd0, 4'd15);
        send_request(OP_ADD_EDGE, 4'd15, 4'd0);
        send_request(OP_ADD_EDGE, 4'd10, 4'd5);
        send_request(OP_ADD_EDGE, 4'd5, 4'd15);
        send_request(OP_BFS, 4'd15, 4'd10);
        send_request(OP_DFS, 4'd0, 4'd5);
    endtask

    // Fill vertex 7 with self loops, try a self loop that finds only one free
    // place, fill the last place and then hit the full list from the other end.
    task automatic test_full_lists();
        send_request(OP_CLEAR, 4'd9, 4'd6);
        repeat (7) send_request(OP_ADD_EDGE, 4'd7, 4'd7);
        send_request(OP_ADD_EDGE, 4'd7, 4'd8);
        send_request(OP_ADD_EDGE, 4'd7, 4'd7);
        send_request(OP_ADD_EDGE, 4'd7, 4'd9);
        send_request(OP_ADD_EDGE, 4'd9, 4'd7);
        send_request(OP_DFS, 4'd7, 4'd0);
        send_request(OP_BFS, 4'd8, 4'd0);
    endtask

    // Lower vertex_count below stored neighbors, then zero, then above range.
    task automatic test_vertex_count_limits();
        wait_until_idle();
        write_vertex_count(5'd8);
        send_request(OP_ADD_EDGE, 4'd8, 4'd0);
        send_request(OP_ADD_EDGE, 4'd0, 4'd8);
        send_request(OP_BFS, 4'd7, 4'd0);   // neighbors 8 and 9 are stale
        send_request(OP_DFS, 4'd9, 4'd0);
        wait_until_idle();
        write_vertex_count(5'd0);
        send_request(OP_ADD_EDGE, 4'd0, 4'd0);
        send_request(OP_BFS, 4'd0, 4'd0);
        wait_until_idle();
        write_vertex_count(5'd31);
        send_request(OP_ADD_EDGE, 4'd15, 4'd14);
        send_request(OP_DFS, 4'd15, 4'd0);
        wait_until_idle();
    endtask

    // Build a ring with two chords, stop taking results for a long stretch
    // and keep offering walks so the block backs up onto its request side.
    task automatic test_output_stall();
        int i;
        write_vertex_count(5'd16);
        send_request(OP_CLEAR, 4'd0, 4'd0);
        for (i = 0; i < NV; i++)
            send_request(OP_ADD_EDGE, VERTEX_W'(i), VERTEX_W'((i + 1) % NV));
        send_request(OP_ADD_EDGE, 4'd0, 4'd8);
        send_request(OP_ADD_EDGE, 4'd4, 4'd12);
        rsp_hold_cycles = 400;
        send_request(OP_BFS, 4'd0, 4'd0);
        send_request(OP_DFS, 4'd5, 4'd0);
        send_request(OP_BFS, 4'd15, 4'd0);
        send_request(OP_DFS, 4'd12, 4'd0);
        wait_until_idle();
    endtask

    // Episodes of: maybe a new vertex_count, maybe a clear, a batch of edges
    // mostly inside the live range, then a few walks mostly from live starts.
    // About one request in ten is noise with any op and any vertices.
    task automatic random_traffic(int budget);
        int                  stop_at, live, n_links;
        logic [VERTEX_W-1:0] a;
        stop_at = requests_sent + budget;
        while (requests_sent < stop_at) begin
            if ($urandom_range(3) == 0) begin
                wait_until_idle();
                case ($urandom_range(7))
                    0:       write_vertex_count(5'd0);
                    1:       write_vertex_count(5'd31);
                    2:       write_vertex_count(5'd1);
                    3:       write_vertex_count(5'd2);
                    4:       write_vertex_count(5'd16);
                    default: write_vertex_count(VCOUNT_W'($urandom_range(3, 16)));
                endcase
            end
            live = (shadow_vcount > NV) ? NV : int'(shadow_vcount);
            if ($urandom_range(2) == 0)
                send_request(OP_CLEAR, VERTEX_W'($urandom_range(15)),
                             VERTEX_W'($urandom_range(15)));
            n_links = $urandom_range(1, 2 * live + 2);
            repeat (n_links) begin
                if (live == 0 || $urandom_range(9) == 0)
                    send_request(t_op'($urandom_range(3)), VERTEX_W'($urandom_range(15)),
                                 VERTEX_W'($urandom_range(15)));
                else
                    send_request(OP_ADD_EDGE, VERTEX_W'($urandom_range(live - 1)),
                                 VERTEX_W'($urandom_range(live - 1)));
            end
            repeat ($urandom_range(1, 4)) begin
                if (live == 0 || $urandom_range(7) == 0)
                    a = VERTEX_W'($urandom_range(15));
                else
                    a = VERTEX_W'($urandom_range(live - 1));
                send_request($urandom_range(1) ? OP_BFS : OP_DFS, a,
                             VERTEX_W'($urandom_range(15)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        // known values on the request and config inputs from time zero
        i_rst_n         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= '0;
        req_ch.valid    <= 1'b0;
        req_ch.op       <= OP_ADD_EDGE;
        req_ch.vertex_a <= '0;
        req_ch.vertex_b <= '0;
        foreach (graph_deg[i]) graph_deg[i] = 0;
        foreach (op_count[i]) op_count[i] = 0;
        shadow_vcount   = VCOUNT_RESET;
        rsp_hold_cycles = 0;
        cycle_count     = 0;
        error_count     = 0;
        requests_sent   = 0;
        results_checked = 0;
        vcount_writes   = 0;
        longest_walk    = 0;

        // sender idles rarely, receiver often
        send_gap_pct = 10;
        rsp_gap_pct  = 78;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_graph();
        test_edge_extremes();
        test_full_lists();
        test_vertex_count_limits();
        test_output_stall();
        random_traffic(100);

        // sender idles often, receiver rarely
        wait_until_idle();
        send_gap_pct = 78;
        rsp_gap_pct  = 10;
        random_traffic(100);

        // no idling on either side
        wait_until_idle();
        send_gap_pct = 0;
        rsp_gap_pct  = 0;
        random_traffic(100);

        // drain, then watch for stray results
        wait_until_idle();
        repeat (64) @(posedge i_clk);
        if (expected_visits.size() != 0) begin
            $error("%0d predicted results never arrived", expected_visits.size());
            error_count++;
        end

        $display("Ran %0d requests (%0d add edge, %0d breadth-first, %0d depth-first, %0d clear)",
                 requests_sent, op_count[OP_ADD_EDGE], op_count[OP_BFS], op_count[OP_DFS],
                 op_count[OP_CLEAR]);
        $display("Checked %0d results over %0d vertex_count writes, longest walk %0d visits",
                 results_checked, vcount_writes, longest_walk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
